// ===== rtl/cao_pkg.sv =====
// ----------------------------------------------------------------------------
// cao_pkg: cursor alpha overlay shared definitions
// Widths, reset values, register map and shared types of the cursor overlay.
// ----------------------------------------------------------------------------
`default_nettype none

package cao_pkg;

  localparam int CURSOR_MAX_SIDE_DEF  = 64;
  localparam int FRAME_COORD_BITS_DEF = 13;

  localparam int PIXEL_BITS  = 32;
  localparam int INDEX_BITS  = 12;
  localparam int CHAN_BITS   = 8;
  localparam int CHANNELS    = 3;
  localparam int DIM_BITS    = 13;
  localparam int SIZE_BITS   = 7;
  localparam int POS_BITS    = 15;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 5;

  localparam logic [DIM_BITS-1:0]  LINE_PIXELS_RST  = 13'd1920;
  localparam logic [DIM_BITS-1:0]  FRAME_LINES_RST  = 13'd1080;
  localparam logic [SIZE_BITS-1:0] CURSOR_SIZE_RST  = 7'd0;
  localparam logic [POS_BITS-1:0]  CURSOR_POS_RST   = 15'd0;

  // Blend arithmetic: x/255 equals (x*32897)>>23 for every sum that can occur.
  localparam logic [CHAN_BITS-1:0] MIX_FULL      = 8'd255;
  localparam logic [15:0]          MIX_ROUND     = 16'd127;
  localparam logic [31:0]          DIV255_MUL    = 32'd32897;
  localparam int                   DIV255_SHIFT  = 23;

  typedef enum logic [0:0] {
    KIND_PIXEL = 1'b0,
    KIND_LOAD  = 1'b1
  } cao_kind_t;

  typedef enum logic [2:0] {
    REG_LINE_PIXELS   = 3'd0,
    REG_FRAME_LINES   = 3'd1,
    REG_CURSOR_WIDTH  = 3'd2,
    REG_CURSOR_HEIGHT = 3'd3,
    REG_CURSOR_LEFT   = 3'd4,
    REG_CURSOR_TOP    = 3'd5
  } cao_reg_t;

  typedef struct packed {
    logic        [DIM_BITS-1:0]  line_pixels;
    logic        [DIM_BITS-1:0]  frame_lines;
    logic        [SIZE_BITS-1:0] cursor_width;
    logic        [SIZE_BITS-1:0] cursor_height;
    logic signed [POS_BITS-1:0]  cursor_left;
    logic signed [POS_BITS-1:0]  cursor_top;
  } cao_cfg_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic [PIXEL_BITS-1:0] word;
  } cao_load_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  hit;
    logic                  eol;
    logic                  eof;
  } cao_px_t;

endpackage

`default_nettype wire

// ===== rtl/cao_in_if.sv =====
// ----------------------------------------------------------------------------
// cao_in_if: cursor overlay input channel
// Carries frame pixels and cursor image loads with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cao_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [cao_pkg::PIXEL_BITS-1:0] pixel;
  logic [cao_pkg::INDEX_BITS-1:0] cursor_index;

  modport source (output valid, kind, pixel, cursor_index, input ready);
  modport sink (input valid, kind, pixel, cursor_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/cao_out_if.sv =====
// ----------------------------------------------------------------------------
// cao_out_if: cursor overlay output channel
// Carries composited pixels with line and frame end marks.
// ----------------------------------------------------------------------------
`default_nettype none

interface cao_out_if;
  logic                           valid;
  logic                           ready;
  logic [cao_pkg::PIXEL_BITS-1:0] pixel_out;
  logic                           end_of_line;
  logic                           end_of_frame;

  modport source (output valid, pixel_out, end_of_line, end_of_frame, input ready);
  modport sink (input valid, pixel_out, end_of_line, end_of_frame, output ready);
endinterface

`default_nettype wire

// ===== rtl/cao_regs.sv =====
// ----------------------------------------------------------------------------
// cao_regs: configuration register file
// APB-style access to frame size, cursor size and cursor corner position.
// ----------------------------------------------------------------------------
`default_nettype none

module cao_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cao_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [cao_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [cao_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output cao_pkg::cao_cfg_t                   cfg
);

  cao_pkg::cao_reg_t reg_sel;

  assign reg_sel = cao_pkg::cao_reg_t'(paddr[cao_pkg::APB_ADDR_BITS-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_pixels   <= cao_pkg::LINE_PIXELS_RST;
      cfg.frame_lines   <= cao_pkg::FRAME_LINES_RST;
      cfg.cursor_width  <= cao_pkg::CURSOR_SIZE_RST;
      cfg.cursor_height <= cao_pkg::CURSOR_SIZE_RST;
      cfg.cursor_left   <= cao_pkg::CURSOR_POS_RST;
      cfg.cursor_top    <= cao_pkg::CURSOR_POS_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        cao_pkg::REG_LINE_PIXELS:   cfg.line_pixels   <= pwdata[cao_pkg::DIM_BITS-1:0];
        cao_pkg::REG_FRAME_LINES:   cfg.frame_lines   <= pwdata[cao_pkg::DIM_BITS-1:0];
        cao_pkg::REG_CURSOR_WIDTH:  cfg.cursor_width  <= pwdata[cao_pkg::SIZE_BITS-1:0];
        cao_pkg::REG_CURSOR_HEIGHT: cfg.cursor_height <= pwdata[cao_pkg::SIZE_BITS-1:0];
        cao_pkg::REG_CURSOR_LEFT:   cfg.cursor_left   <= pwdata[cao_pkg::POS_BITS-1:0];
        cao_pkg::REG_CURSOR_TOP:    cfg.cursor_top    <= pwdata[cao_pkg::POS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      cao_pkg::REG_LINE_PIXELS:   prdata = 32'(cfg.line_pixels);
      cao_pkg::REG_FRAME_LINES:   prdata = 32'(cfg.frame_lines);
      cao_pkg::REG_CURSOR_WIDTH:  prdata = 32'(cfg.cursor_width);
      cao_pkg::REG_CURSOR_HEIGHT: prdata = 32'(cfg.cursor_height);
      cao_pkg::REG_CURSOR_LEFT:   prdata = 32'($unsigned(cfg.cursor_left));
      cao_pkg::REG_CURSOR_TOP:    prdata = 32'($unsigned(cfg.cursor_top));
      default:                    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/cao_store.sv =====
// ----------------------------------------------------------------------------
// cao_store: cursor image memory
// Single-port-write, registered-read store with a staged write address and
// forwarding of a write that lands on the entry being read.
// ----------------------------------------------------------------------------
`default_nettype none

module cao_store #(
  parameter int CURSOR_MAX_SIDE = cao_pkg::CURSOR_MAX_SIDE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_valid,
  input  cao_pkg::cao_load_t                   wr_req,
  input  logic                                 rd_en,
  input  logic [$clog2(CURSOR_MAX_SIDE*CURSOR_MAX_SIDE)-1:0] rd_addr,
  output logic [cao_pkg::PIXEL_BITS-1:0]       rd_word
);

  localparam int DEPTH    = CURSOR_MAX_SIDE * CURSOR_MAX_SIDE;
  localparam int AW       = $clog2(DEPTH);
  localparam int RSHIFT   = cao_pkg::INDEX_BITS + $clog2(DEPTH);
  localparam int RECIP    = ((1 << RSHIFT) + DEPTH - 1) / DEPTH;

  logic [cao_pkg::PIXEL_BITS-1:0] mem [DEPTH];

  logic                           ld_valid;
  logic [cao_pkg::INDEX_BITS-1:0] ld_index;
  logic [cao_pkg::INDEX_BITS-1:0] ld_quot;
  logic [cao_pkg::PIXEL_BITS-1:0] ld_word;
  logic [31:0]                    quot_prod;
  logic [31:0]                    wr_full;
  logic [AW-1:0]                  wr_addr;

  logic [cao_pkg::PIXEL_BITS-1:0] mem_q;
  logic                           fwd_hit;
  logic [cao_pkg::PIXEL_BITS-1:0] fwd_word;

  // The index wraps modulo the store depth: quotient first, remainder next cycle.
  assign quot_prod = 32'(wr_req.index) * 32'(RECIP);
  assign wr_full   = 32'(ld_index) - 32'(ld_quot) * 32'(DEPTH);
  assign wr_addr   = wr_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_valid <= 1'b0;
    end else begin
      ld_valid <= wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      ld_index <= wr_req.index;
      ld_quot  <= cao_pkg::INDEX_BITS'(quot_prod >> RSHIFT);
      ld_word  <= wr_req.word;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_valid) begin
      mem[wr_addr] <= ld_word;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd_hit  <= ld_valid && (wr_addr == rd_addr);
      fwd_word <= ld_word;
    end
  end

  assign rd_word = fwd_hit ? fwd_word : mem_q;

endmodule

`default_nettype wire

// ===== rtl/cao_blend.sv =====
// ----------------------------------------------------------------------------
// cao_blend: alpha blend pipeline
// Mixes cursor and frame channels (cursor hit, nonzero alpha; else pass-through)
// and divides by 255 in two stages, then holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cao_blend (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           px_valid,
  output logic                           px_ready,
  input  cao_pkg::cao_px_t               px,
  input  logic [cao_pkg::PIXEL_BITS-1:0] cursor_word,
  cao_out_if.source                      out_ch
);

  localparam int CB = cao_pkg::CHAN_BITS;

  logic             v0;
  logic             v1;
  logic             v2;
  logic             r0;
  logic             r1;
  logic             r2;
  cao_pkg::cao_px_t px0;

  logic [CB-1:0]    alpha;
  logic             mix_en;
  logic [15:0]      mix_sum  [cao_pkg::CHANNELS];

  logic [cao_pkg::PIXEL_BITS-1:0] s1_pixel;
  logic                           s1_en;
  logic                           s1_eol;
  logic                           s1_eof;
  logic [15:0]                    s1_sum [cao_pkg::CHANNELS];

  logic [31:0]                    div_prod [cao_pkg::CHANNELS];
  logic [cao_pkg::PIXEL_BITS-1:0] mixed;

  logic [cao_pkg::PIXEL_BITS-1:0] out_pixel;
  logic                           out_eol;
  logic                           out_eof;

  assign r2       = !v2 || out_ch.ready;
  assign r1       = !v1 || r2;
  assign r0       = !v0 || r1;
  assign px_ready = r0;

  assign alpha  = cursor_word[cao_pkg::PIXEL_BITS-1 -: CB];
  assign mix_en = px0.hit && (alpha != '0);

  always_comb begin
    for (int ch = 0; ch < cao_pkg::CHANNELS; ch++) begin
      mix_sum[ch] = 16'(cursor_word[ch*CB +: CB]) * 16'(alpha)
                  + 16'(px0.pixel[ch*CB +: CB]) * 16'(cao_pkg::MIX_FULL - alpha)
                  + cao_pkg::MIX_ROUND;
    end
  end

  always_comb begin
    mixed = s1_pixel;
    for (int ch = 0; ch < cao_pkg::CHANNELS; ch++) begin
      div_prod[ch] = 32'(s1_sum[ch]) * cao_pkg::DIV255_MUL;
      if (s1_en) begin
        mixed[ch*CB +: CB] = div_prod[ch][cao_pkg::DIV255_SHIFT +: CB];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (r0) begin
        v0 <= px_valid;
      end
      if (r1) begin
        v1 <= v0;
      end
      if (r2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r0 && px_valid) begin
      px0 <= px;
    end
    if (r1 && v0) begin
      s1_pixel <= px0.pixel;
      s1_en    <= mix_en;
      s1_eol   <= px0.eol;
      s1_eof   <= px0.eof;
      s1_sum   <= mix_sum;
    end
    if (r2 && v1) begin
      out_pixel <= mixed;
      out_eol   <= s1_eol;
      out_eof   <= s1_eof;
    end
  end

  assign out_ch.valid        = v2;
  assign out_ch.pixel_out    = out_pixel;
  assign out_ch.end_of_line  = out_eol;
  assign out_ch.end_of_frame = out_eof;

endmodule

`default_nettype wire

// ===== rtl/cursor_alpha_overlay_unit.sv =====
// ----------------------------------------------------------------------------
// cursor_alpha_overlay_unit: hardware cursor overlay with alpha blending
// A frame pixel accepted on the input is registered in the input stage, then in
// the mix stage and then in the output register, from which it can be taken; one
// beat per cycle is taken sustained while the output accepts. Cursor loads take
// one beat each and produce no output beat. Reset clears the registers, the line
// counters and pipeline control; the cursor store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_alpha_overlay_unit #(
  parameter int CURSOR_MAX_SIDE  = cao_pkg::CURSOR_MAX_SIDE_DEF,
  parameter int FRAME_COORD_BITS = cao_pkg::FRAME_COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  cao_in_if.sink                            in_ch,
  cao_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cao_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [cao_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [cao_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);

  localparam int CW = FRAME_COORD_BITS;
  localparam int DW = ((CW > cao_pkg::POS_BITS) ? CW : cao_pkg::POS_BITS) + 2;
  localparam int SW = $clog2(CURSOR_MAX_SIDE + 1);
  localparam int IB = $clog2(CURSOR_MAX_SIDE);
  localparam int AW = $clog2(CURSOR_MAX_SIDE * CURSOR_MAX_SIDE);

  cao_pkg::cao_cfg_t  cfg;
  cao_pkg::cao_load_t wr_req;
  cao_pkg::cao_px_t   px;

  logic          px_valid;
  logic          px_ready;
  logic          px_take;
  logic          wr_valid;
  logic [cao_pkg::PIXEL_BITS-1:0] cursor_word;

  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;
  logic [CW-1:0] fw;
  logic [CW-1:0] fh;
  logic [CW-1:0] col_last;
  logic [CW-1:0] row_last;
  logic          eol;
  logic          eof;

  logic [SW-1:0]        cw_sat;
  logic [SW-1:0]        ch_sat;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic                 hit;
  logic [AW-1:0]        rd_addr;

  cao_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ch.ready = px_ready;
  assign px_valid    = in_ch.valid && (in_ch.kind == cao_pkg::KIND_PIXEL);
  assign px_take     = px_valid && px_ready;
  assign wr_valid    = in_ch.valid && px_ready && (in_ch.kind == cao_pkg::KIND_LOAD);
  assign wr_req      = '{index: in_ch.cursor_index, word: in_ch.pixel};

  assign fw       = CW'(cfg.line_pixels);
  assign fh       = CW'(cfg.frame_lines);
  assign col_last = (fw == '0) ? '0 : fw - CW'(1);
  assign row_last = (fh == '0) ? '0 : fh - CW'(1);
  assign eol      = column_count >= col_last;
  assign eof      = eol && (row_count >= row_last);

  assign cw_sat = (32'(cfg.cursor_width) > 32'(CURSOR_MAX_SIDE)) ?
                  SW'(CURSOR_MAX_SIDE) : SW'(cfg.cursor_width);
  assign ch_sat = (32'(cfg.cursor_height) > 32'(CURSOR_MAX_SIDE)) ?
                  SW'(CURSOR_MAX_SIDE) : SW'(cfg.cursor_height);

  assign dx  = $signed({{(DW-CW){1'b0}}, column_count})
             - $signed({{(DW-cao_pkg::POS_BITS){cfg.cursor_left[cao_pkg::POS_BITS-1]}},
                        cfg.cursor_left});
  assign dy  = $signed({{(DW-CW){1'b0}}, row_count})
             - $signed({{(DW-cao_pkg::POS_BITS){cfg.cursor_top[cao_pkg::POS_BITS-1]}},
                        cfg.cursor_top});
  assign hit = !dx[DW-1] && !dy[DW-1]
            && ($unsigned(dx) < DW'(cw_sat)) && ($unsigned(dy) < DW'(ch_sat));
  assign rd_addr = AW'(dy[IB-1:0]) * AW'(CURSOR_MAX_SIDE) + AW'(dx[IB-1:0]);

  assign px = '{pixel: in_ch.pixel, hit: hit, eol: eol, eof: eof};

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (px_take) begin
      if (eol) begin
        column_count <= '0;
        row_count    <= eof ? '0 : row_count + CW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  cao_store #(
    .CURSOR_MAX_SIDE (CURSOR_MAX_SIDE)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (wr_valid),
    .wr_req   (wr_req),
    .rd_en    (px_take),
    .rd_addr  (rd_addr),
    .rd_word  (cursor_word)
  );

  cao_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .px_valid    (px_valid),
    .px_ready    (px_ready),
    .px          (px),
    .cursor_word (cursor_word),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire
